/* sv/sccs_history_tokenizer_macros.svh */
// Assertion helpers for the history tokenizer.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef SCCS_HISTORY_TOKENIZER_MACROS_SVH
`define SCCS_HISTORY_TOKENIZER_MACROS_SVH

// Condition must hold at every clock edge.
`define SHT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sht_pkg.sv */
package sht_pkg;

    // Token kinds
    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_TEXT    = 5'd1;
    localparam logic [4:0] KIND_COMMENT = 5'd2;
    localparam logic [4:0] KIND_STRING  = 5'd3;
    localparam logic [4:0] KIND_KEY0    = 5'd4;
    localparam logic [4:0] KIND_JUNK    = 5'd20;

    // Special bytes
    localparam logic [7:0] BYTE_SOH     = 8'h01;
    localparam logic [7:0] BYTE_NL      = 8'h0A;
    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_COMMENT = 8'h63;  // 'c'

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_TEXT   = 3'd1,
        PH_KEY    = 3'd2,
        PH_CFIRST = 3'd3,
        PH_CBODY  = 3'd4,
        PH_MID    = 3'd5
    } lex_phase_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] data;
        logic       present;
        logic       tok_last;
        logic       run_last;
    } token_item_t;

    // Keyword letter to token kind; anything unknown is junk
    function automatic logic [4:0] key_kind(input logic [7:0] b);
        logic [4:0] k;
        case (b)
            8'h64:   k = KIND_KEY0;           // d
            8'h44:   k = KIND_KEY0 + 5'd1;    // D
            8'h65:   k = KIND_KEY0 + 5'd2;    // e
            8'h45:   k = KIND_KEY0 + 5'd3;    // E
            8'h66:   k = KIND_KEY0 + 5'd4;    // f
            8'h67:   k = KIND_KEY0 + 5'd5;    // g
            8'h68:   k = KIND_KEY0 + 5'd6;    // h
            8'h69:   k = KIND_KEY0 + 5'd7;    // i
            8'h49:   k = KIND_KEY0 + 5'd8;    // I
            8'h6D:   k = KIND_KEY0 + 5'd9;    // m
            8'h73:   k = KIND_KEY0 + 5'd10;   // s
            8'h74:   k = KIND_KEY0 + 5'd11;   // t
            8'h54:   k = KIND_KEY0 + 5'd12;   // T
            8'h75:   k = KIND_KEY0 + 5'd13;   // u
            8'h55:   k = KIND_KEY0 + 5'd14;   // U
            8'h78:   k = KIND_KEY0 + 5'd15;   // x
            default: k = KIND_JUNK;
        endcase
        return k;
    endfunction

    // Separator bytes for string tokens
    function automatic logic is_space(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b == 8'h09) || (b == BYTE_NL) ||
               (b == 8'h0B) || (b == 8'h0C) || (b == 8'h0D);
    endfunction

endpackage

/* sv/sccs_history_tokenizer.sv */
// History file tokenizer.
// Input stream (s_*): one file byte per beat in s_tdata; s_tuser high marks
// end of file, s_tdata is then ignored.
// Output stream (m_*): one token item per beat. m_tdata is the token byte,
// m_tuser holds kind, byte-present and token-last, m_tlast marks the last
// item caused by one input beat.
// Timing: items of an input beat are in the output queue the cycle after it is taken.
// Throughput: one input beat per cycle while s_tready is high; a byte beat
// gives zero or one item, an end-of-file beat up to two (closing item plus
// end item). The bound is the single write-two read-one output queue of four
// entries; the input side is ready while two slots are free.
// Token bytes come out one beat behind, so the last byte can carry token-last.
// Reset: lexer returns to line start, held byte and queue are emptied.
// Receiver stall: the queue fills and s_tready drops once fewer than two
// slots remain; nothing is lost. After end of file only further end-of-file
// beats give items (one end item each) until the next reset.
`include "sccs_history_tokenizer_macros.svh"

module sccs_history_tokenizer
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tuser,    // [0] end_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] token_byte
    output logic [6:0] m_tuser,    // [4:0] token_kind, [5] byte_present, [6] token_last
    output logic       m_tlast     // run_last
);
    import sht_pkg::*;

    lex_phase_t             phase_reg, phase_next;
    logic [7:0]             held_byte_reg, held_byte_next;
    logic                   held_valid_reg, held_valid_next;
    logic [4:0]             held_kind_reg, held_kind_next;
    logic                   ended_reg, ended_next;

    token_item_t            fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]       cnt_reg;

    logic                   in_accept;
    logic                   out_pop;
    token_item_t            res0, res1;
    logic [1:0]             res_cnt;

    // Step control
    logic                   close_req, push_req, put_req, end_req;
    logic [4:0]             close_kind, push_kind, put_kind;
    logic                   emit;
    token_item_t            emit_item;

    assign s_tready  = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != '0);
    assign out_pop   = m_tvalid && m_tready;

    // Lexer step: classify the accepted beat
    always_comb
    begin
        phase_next      = phase_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_kind_next  = held_kind_reg;
        ended_next      = ended_reg;
        close_req       = 1'b0;
        push_req        = 1'b0;
        put_req         = 1'b0;
        end_req         = 1'b0;
        close_kind      = KIND_TEXT;
        push_kind       = KIND_TEXT;
        put_kind        = KIND_JUNK;

        if (in_accept)
        begin
            if (ended_reg)
            begin
                end_req = s_tuser;
            end
            else if (s_tuser)
            begin
                case (phase_reg)
                    PH_LINE:
                    begin
                    end
                    PH_TEXT:
                    begin
                        close_req  = 1'b1;
                        close_kind = KIND_TEXT;
                    end
                    PH_KEY:
                    begin
                        put_req  = 1'b1;
                        put_kind = KIND_JUNK;
                    end
                    PH_CFIRST, PH_CBODY:
                    begin
                        close_req  = 1'b1;
                        close_kind = KIND_COMMENT;
                    end
                    default:
                    begin
                        close_req  = held_valid_reg;
                        close_kind = KIND_STRING;
                    end
                endcase
                end_req    = 1'b1;
                ended_next = 1'b1;
                phase_next = PH_LINE;
            end
            else
            begin
                case (phase_reg)
                    PH_LINE:
                    begin
                        if (s_tdata == BYTE_SOH)
                        begin
                            phase_next = PH_KEY;
                        end
                        else if (s_tdata == BYTE_NL)
                        begin
                            put_req  = 1'b1;
                            put_kind = KIND_TEXT;
                        end
                        else
                        begin
                            push_req   = 1'b1;
                            push_kind  = KIND_TEXT;
                            phase_next = PH_TEXT;
                        end
                    end
                    PH_TEXT:
                    begin
                        if (s_tdata == BYTE_NL)
                        begin
                            close_req  = 1'b1;
                            close_kind = KIND_TEXT;
                            phase_next = PH_LINE;
                        end
                        else
                        begin
                            push_req  = 1'b1;
                            push_kind = KIND_TEXT;
                        end
                    end
                    PH_KEY:
                    begin
                        if (s_tdata == BYTE_COMMENT)
                        begin
                            phase_next = PH_CFIRST;
                        end
                        else
                        begin
                            put_req    = 1'b1;
                            put_kind   = key_kind(s_tdata);
                            phase_next = (s_tdata == BYTE_NL) ? PH_LINE : PH_MID;
                        end
                    end
                    PH_CFIRST:
                    begin
                        if (s_tdata == BYTE_NL)
                        begin
                            close_req  = 1'b1;
                            close_kind = KIND_COMMENT;
                            phase_next = PH_LINE;
                        end
                        else
                        begin
                            // one leading space of a comment is dropped
                            push_req   = (s_tdata != BYTE_SPACE);
                            push_kind  = KIND_COMMENT;
                            phase_next = PH_CBODY;
                        end
                    end
                    PH_CBODY:
                    begin
                        if (s_tdata == BYTE_NL)
                        begin
                            close_req  = 1'b1;
                            close_kind = KIND_COMMENT;
                            phase_next = PH_LINE;
                        end
                        else
                        begin
                            push_req  = 1'b1;
                            push_kind = KIND_COMMENT;
                        end
                    end
                    default:
                    begin
                        if (is_space(s_tdata))
                        begin
                            close_req  = held_valid_reg;
                            close_kind = KIND_STRING;
                            phase_next = (s_tdata == BYTE_NL) ? PH_LINE : PH_MID;
                        end
                        else
                        begin
                            push_req   = 1'b1;
                            push_kind  = KIND_STRING;
                            phase_next = PH_MID;
                        end
                    end
                endcase
            end
        end

        // Token item of this step, before the end item
        emit      = 1'b0;
        emit_item = '0;
        if (close_req)
        begin
            emit = 1'b1;
            if (held_valid_reg)
                emit_item = '{kind: held_kind_reg, data: held_byte_reg, present: 1'b1,
                              tok_last: 1'b1, run_last: 1'b0};
            else
                emit_item = '{kind: close_kind, data: 8'h00, present: 1'b0,
                              tok_last: 1'b1, run_last: 1'b0};
            held_valid_next = 1'b0;
        end
        if (push_req)
        begin
            emit      = held_valid_reg;
            emit_item = '{kind: held_kind_reg, data: held_byte_reg, present: 1'b1,
                          tok_last: 1'b0, run_last: 1'b0};
            held_byte_next  = s_tdata;
            held_kind_next  = push_kind;
            held_valid_next = 1'b1;
        end
        if (put_req)
        begin
            emit      = 1'b1;
            emit_item = '{kind: put_kind, data: 8'h00, present: 1'b0,
                          tok_last: 1'b1, run_last: 1'b0};
        end
        if (end_req)
            held_valid_next = 1'b0;
    end

    // Assemble up to two items; the final one closes the run
    always_comb
    begin
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        if (end_req && emit)
        begin
            res0    = emit_item;
            res1    = '{kind: KIND_END, data: 8'h00, present: 1'b0,
                        tok_last: 1'b1, run_last: 1'b1};
            res_cnt = 2'd2;
        end
        else if (end_req)
        begin
            res0    = '{kind: KIND_END, data: 8'h00, present: 1'b0,
                        tok_last: 1'b1, run_last: 1'b1};
            res_cnt = 2'd1;
        end
        else if (emit)
        begin
            res0          = emit_item;
            res0.run_last = 1'b1;
            res_cnt       = 2'd1;
        end
    end

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LINE;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_kind_reg  <= '0;
            ended_reg      <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_kind_reg  <= held_kind_next;
            ended_reg      <= ended_next;
        end
    end

    // Output queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(out_pop);
            cnt_reg    <= cnt_reg + CNT_W'(res_cnt) - CNT_W'(out_pop);
        end
    end

    // Output queue storage
    always_ff @(posedge clk)
    begin
        if (res_cnt != 2'd0)
            fifo_reg[wr_ptr_reg] <= res0;
        if (res_cnt == 2'd2)
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
    end

    assign m_tdata = fifo_reg[rd_ptr_reg].data;
    assign m_tuser = {fifo_reg[rd_ptr_reg].tok_last, fifo_reg[rd_ptr_reg].present,
                      fifo_reg[rd_ptr_reg].kind};
    assign m_tlast = fifo_reg[rd_ptr_reg].run_last;

    // Checks
    `SHT_ASSERT_ALWAYS(a_fifo_bound, cnt_reg <= CNT_W'(FIFO_DEPTH), "output queue overflow")
    `SHT_ASSERT_ALWAYS(a_held_phase, !held_valid_reg || phase_reg == PH_TEXT || phase_reg == PH_CBODY || phase_reg == PH_MID, "held byte outside a token phase")
    `SHT_ASSERT_ALWAYS(a_ended_idle, !ended_reg || (!held_valid_reg && phase_reg == PH_LINE), "lexer active after end of file")
    `SHT_ASSERT_NEXT(a_eof_sets_end, in_accept && s_tuser, ended_reg, "end of file not recorded")
    `SHT_ASSERT_NEXT(a_after_end_quiet, in_accept && ended_reg && !s_tuser && !out_pop, cnt_reg == $past(cnt_reg), "item produced after end of file")

endmodule

/* tb/sccs_history_tokenizer_tb.sv */
`timescale 1ns / 100ps

module sccs_history_tokenizer_tb;
    import sht_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 750;
    localparam int DRAIN_CYCLES = 20;

    // separators besides space and newline
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_VT  = 8'h0B;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;

    // keyword letters in kind order, first letter in the top byte
    localparam logic [127:0] KEY_LETTERS = "dDeEfghiImstTuUx";

    // how a directed row is checked
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_NONE    = 2'd1;
    localparam logic [1:0] ROW_ONE     = 2'd2;

    typedef struct packed {
        logic [7:0]  b;
        logic [1:0]  how;
        token_item_t item;
    } dir_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [6:0] m_tuser;
    logic       m_tlast;

    // tokenizer state as predicted
    lex_phase_t lex_st   = PH_LINE;
    logic [7:0] held_b   = 8'h00;
    logic       held_v   = 1'b0;
    logic [4:0] held_k   = 5'd0;
    logic       eof_seen = 1'b0;

    token_item_t beat_items[$];
    token_item_t tokens_due[$];
    dir_row_t    dir_rows[$];

    int send_idle     = 31;
    int recv_idle     = 48;
    int beats_sent    = 0;
    int items_checked = 0;
    int mismatches    = 0;
    int cycles        = 0;
    string end_case   = "at line start";

    sccs_history_tokenizer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] in_byte
        .s_tuser  (s_tuser),    // [0] end_of_file
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] token_byte
        .m_tuser  (m_tuser),    // [4:0] token_kind, [5] byte_present, [6] token_last
        .m_tlast  (m_tlast)     // run_last
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d items outstanding",
                     cycles, tokens_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------

    function automatic void add_item(input logic [4:0] k, input logic [7:0] b,
                                     input logic pres, input logic last);
        token_item_t t;
        t.kind     = k;
        t.data     = pres ? b : 8'h00;
        t.present  = pres;
        t.tok_last = last;
        t.run_last = 1'b0;
        if (beat_items.size() < 2)
            beat_items.push_back(t);
    endfunction

    // close the open token: last held byte, or an empty item
    function automatic void finish_token(input logic [4:0] k);
        if (held_v)
            add_item(held_k, held_b, 1'b1, 1'b1);
        else
            add_item(k, 8'h00, 1'b0, 1'b1);
        held_v = 1'b0;
    endfunction

    // hold the new byte, release the previous one
    function automatic void extend_token(input logic [4:0] k, input logic [7:0] b);
        if (held_v)
            add_item(held_k, held_b, 1'b1, 1'b0);
        held_b = b;
        held_k = k;
        held_v = 1'b1;
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_NL) ||
               (b == BYTE_VT) || (b == BYTE_FF) || (b == BYTE_CR);
    endfunction

    function automatic logic [4:0] letter_kind(input logic [7:0] b);
        int k;
        k = KIND_JUNK;
        for (int i = 0; i < 16; i++)
            if (KEY_LETTERS[127 - 8*i -: 8] == b)
                k = KIND_KEY0 + i;
        return 5'(k);
    endfunction

    // items caused by one accepted beat land in beat_items
    function automatic void tokenize_beat(input logic [7:0] b, input logic eof);
        token_item_t t;
        beat_items.delete();
        if (eof_seen)
        begin
            if (eof)
                add_item(KIND_END, 8'h00, 1'b0, 1'b1);
        end
        else if (eof)
        begin
            case (lex_st)
                PH_LINE:             ;
                PH_TEXT:             finish_token(KIND_TEXT);
                PH_KEY:              add_item(KIND_JUNK, 8'h00, 1'b0, 1'b1);
                PH_CFIRST, PH_CBODY: finish_token(KIND_COMMENT);
                default:
                begin
                    if (held_v)
                        finish_token(KIND_STRING);
                end
            endcase
            held_v = 1'b0;
            add_item(KIND_END, 8'h00, 1'b0, 1'b1);
            eof_seen = 1'b1;
            lex_st   = PH_LINE;
        end
        else
        begin
            case (lex_st)
                PH_LINE:
                begin
                    if (b == BYTE_SOH)
                        lex_st = PH_KEY;
                    else if (b == BYTE_NL)
                        add_item(KIND_TEXT, 8'h00, 1'b0, 1'b1);
                    else
                    begin
                        extend_token(KIND_TEXT, b);
                        lex_st = PH_TEXT;
                    end
                end
                PH_TEXT:
                begin
                    if (b == BYTE_NL)
                    begin
                        finish_token(KIND_TEXT);
                        lex_st = PH_LINE;
                    end
                    else
                        extend_token(KIND_TEXT, b);
                end
                PH_KEY:
                begin
                    if (b == BYTE_COMMENT)
                        lex_st = PH_CFIRST;
                    else
                    begin
                        add_item(letter_kind(b), 8'h00, 1'b0, 1'b1);
                        lex_st = (b == BYTE_NL) ? PH_LINE : PH_MID;
                    end
                end
                PH_CFIRST:
                begin
                    if (b == BYTE_NL)
                    begin
                        finish_token(KIND_COMMENT);
                        lex_st = PH_LINE;
                    end
                    else
                    begin
                        // one leading space is dropped
                        if (b != BYTE_SPACE)
                            extend_token(KIND_COMMENT, b);
                        lex_st = PH_CBODY;
                    end
                end
                PH_CBODY:
                begin
                    if (b == BYTE_NL)
                    begin
                        finish_token(KIND_COMMENT);
                        lex_st = PH_LINE;
                    end
                    else
                        extend_token(KIND_COMMENT, b);
                end
                default:
                begin
                    if (is_separator(b))
                    begin
                        if (held_v)
                            finish_token(KIND_STRING);
                        lex_st = (b == BYTE_NL) ? PH_LINE : PH_MID;
                    end
                    else
                    begin
                        extend_token(KIND_STRING, b);
                        lex_st = PH_MID;
                    end
                end
            endcase
        end
        // mark the last item of this beat
        if (beat_items.size() > 0)
        begin
            t = beat_items.pop_back();
            t.run_last = 1'b1;
            beat_items.push_back(t);
        end
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    task automatic drive_beat(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= eof;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        beats_sent++;
        tokenize_beat(b, eof);
    endtask

    task automatic send_beat(input logic [7:0] b, input logic eof);
        drive_beat(b, eof);
        foreach (beat_items[i])
            tokens_due.push_back(beat_items[i]);
    endtask

    // sender stops until every expected item has come out
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic [1:0] how,
                           input logic [4:0] k, input logic [7:0] d,
                           input logic pres, input logic last);
        dir_row_t r;
        r.b             = b;
        r.how           = how;
        r.item.kind     = k;
        r.item.data     = d;
        r.item.present  = pres;
        r.item.tok_last = last;
        r.item.run_last = 1'b1;
        dir_rows.push_back(r);
    endtask

    // half printable, half any byte; word bytes exclude separators
    function automatic logic [7:0] pick_byte(input logic word_only);
        logic [7:0] b;
        do
        begin
            if ($urandom_range(1))
                b = 8'($urandom_range(126, 33));
            else
                b = 8'($urandom_range(255));
        end
        while (word_only ? is_separator(b) : (b == BYTE_NL));
        return b;
    endfunction

    function automatic logic [7:0] pick_separator();
        logic [7:0] b;
        case ($urandom_range(4))
            0:       b = BYTE_SPACE;
            1:       b = BYTE_TAB;
            2:       b = BYTE_VT;
            3:       b = BYTE_FF;
            default: b = BYTE_CR;
        endcase
        return b;
    endfunction

    // one line of a history file, mostly well formed
    task automatic send_history_line();
        int         sel;
        int         n;
        int         words;
        logic [7:0] b;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            // plain text line
            n = $urandom_range(10);
            for (int i = 0; i < n; i++)
            begin
                b = pick_byte(1'b0);
                if (i == 0 && b == BYTE_SOH)
                    b = "A";
                send_beat(b, 1'b0);
            end
            send_beat(BYTE_NL, 1'b0);
        end
        else if (sel < 88 && !(sel >= 60 && sel < 80))
        begin
            // keyword line, or a junk letter below 30% of these
            send_beat(BYTE_SOH, 1'b0);
            if (sel < 60)
                b = KEY_LETTERS[127 - 8*$urandom_range(15) -: 8];
            else
                b = 8'($urandom_range(255));
            send_beat(b, 1'b0);
            words = $urandom_range(4);
            for (int w = 0; w < words; w++)
            begin
                n = $urandom_range(2, w == 0 ? 1 : 0);
                if ($urandom_range(7) == 0)
                    n = 0;
                for (int i = 0; i < n; i++)
                    send_beat(pick_separator(), 1'b0);
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++)
                    send_beat(pick_byte(1'b1), 1'b0);
            end
            if ($urandom_range(3) == 0)
                send_beat(pick_separator(), 1'b0);
            send_beat(BYTE_NL, 1'b0);
        end
        else if (sel < 80)
        begin
            // comment line
            send_beat(BYTE_SOH, 1'b0);
            send_beat(BYTE_COMMENT, 1'b0);
            n = $urandom_range(2);
            if (n != 0)
            begin
                if (n == 1)
                    send_beat(BYTE_SPACE, 1'b0);
                n = $urandom_range(10);
                for (int i = 0; i < n; i++)
                    send_beat(pick_byte(1'b0), 1'b0);
            end
            send_beat(BYTE_NL, 1'b0);
        end
        else
        begin
            // raw noise, no line structure
            n = $urandom_range(12, 1);
            for (int i = 0; i < n; i++)
                send_beat(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // ---------------------------------------------------------------
    // Output side: stall pattern and check
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : out_side
        token_item_t got;
        token_item_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_idle);
            if (m_tvalid && m_tready)
            begin
                got.kind     = m_tuser[4:0];
                got.data     = m_tdata;
                got.present  = m_tuser[5];
                got.tok_last = m_tuser[6];
                got.run_last = m_tlast;
                if (tokens_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item kind %0d byte %h present %0b last %0b run %0b",
                             $time, got.kind, got.data, got.present, got.tok_last,
                             got.run_last);
                end
                else
                begin
                    want = tokens_due.pop_front();
                    items_checked++;
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.present !== want.present || got.tok_last !== want.tok_last ||
                        got.run_last !== want.run_last)
                    begin
                        mismatches++;
                        $display("%0t: expected kind %0d byte %h present %0b last %0b run %0b",
                                 $time, want.kind, want.data, want.present, want.tok_last,
                                 want.run_last);
                        $display("%0t:   actual kind %0d byte %h present %0b last %0b run %0b",
                                 $time, got.kind, got.data, got.present, got.tok_last,
                                 got.run_last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        int dir_beats;
        int sel;
        int n;

        // directed walk through every line form
        add_row(BYTE_NL,      ROW_ONE,     KIND_TEXT,    8'h00, 1'b0, 1'b1);  // empty text line
        add_row(8'h00,        ROW_NONE,    KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(8'hFF,        ROW_ONE,     KIND_TEXT,    8'h00, 1'b1, 1'b0);
        add_row(BYTE_NL,      ROW_ONE,     KIND_TEXT,    8'hFF, 1'b1, 1'b1);
        add_row(BYTE_SOH,     ROW_NONE,    KIND_END,     8'h00, 1'b0, 1'b0);
        add_row("d",          ROW_ONE,     KIND_KEY0,    8'h00, 1'b0, 1'b1);
        add_row("a",          ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_TAB,     ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(8'hFF,        ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_NL,      ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_SOH,     ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row("Q",          ROW_ONE,     KIND_JUNK,    8'h00, 1'b0, 1'b1);
        add_row(BYTE_NL,      ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        // newline right after 0x01 is junk
        add_row(BYTE_SOH,     ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_NL,      ROW_ONE,     KIND_JUNK,    8'h00, 1'b0, 1'b1);
        // newline right after the comment letter: empty comment
        add_row(BYTE_SOH,     ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_COMMENT, ROW_NONE,    KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_NL,      ROW_ONE,     KIND_COMMENT, 8'h00, 1'b0, 1'b1);
        // only the first of two leading spaces is dropped
        add_row(BYTE_SOH,     ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_COMMENT, ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_SPACE,   ROW_NONE,    KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_SPACE,   ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row("k",          ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_NL,      ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row(BYTE_SOH,     ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);
        add_row("x",          ROW_ONE,     KIND_KEY0 + 5'd15, 8'h00, 1'b0, 1'b1);
        add_row(BYTE_NL,      ROW_PREDICT, KIND_END,     8'h00, 1'b0, 1'b0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            drive_beat(dir_rows[i].b, 1'b0);
            case (dir_rows[i].how)
                ROW_ONE:  tokens_due.push_back(dir_rows[i].item);
                ROW_NONE: ;
                default:
                begin
                    foreach (beat_items[j])
                        tokens_due.push_back(beat_items[j]);
                end
            endcase
        end
        dir_beats = beats_sent;
        hold_until_drained();

        // random file body, idle pattern changes each third
        while (beats_sent < dir_beats + RANDOM_BEATS)
        begin
            if (send_idle == 31 && beats_sent >= dir_beats + RANDOM_BEATS / 3)
            begin
                hold_until_drained();
                send_idle = 48;
                recv_idle = 31;
            end
            else if (send_idle == 48 && beats_sent >= dir_beats + 2 * RANDOM_BEATS / 3)
            begin
                hold_until_drained();
                send_idle = 0;
                recv_idle = 0;
            end
            send_history_line();
        end

        // leave the lexer in one chosen phase, then end the file
        send_beat(BYTE_NL, 1'b0);
        sel = $urandom_range(6);
        case (sel)
            1:
            begin
                end_case = "in a text line";
                send_beat("a", 1'b0);
                send_beat("b", 1'b0);
            end
            2:
            begin
                end_case = "right after 0x01";
                send_beat(BYTE_SOH, 1'b0);
            end
            3:
            begin
                end_case = "right after the comment letter";
                send_beat(BYTE_SOH, 1'b0);
                send_beat(BYTE_COMMENT, 1'b0);
            end
            4:
            begin
                end_case = "in a comment body";
                send_beat(BYTE_SOH, 1'b0);
                send_beat(BYTE_COMMENT, 1'b0);
                send_beat(BYTE_SPACE, 1'b0);
                send_beat("z", 1'b0);
            end
            5:
            begin
                end_case = "inside a string";
                send_beat(BYTE_SOH, 1'b0);
                send_beat("d", 1'b0);
                send_beat(BYTE_SPACE, 1'b0);
                send_beat("w", 1'b0);
            end
            6:
            begin
                end_case = "between strings";
                send_beat(BYTE_SOH, 1'b0);
                send_beat("d", 1'b0);
                send_beat(BYTE_SPACE, 1'b0);
            end
            default: ;
        endcase
        send_beat(8'($urandom_range(255)), 1'b1);

        // after the end only end markers give items
        n = $urandom_range(8, 2);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(255)), (i == 0) ? 1'b1 : 1'($urandom_range(1)));

        s_tvalid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d beats (%0d directed) and checked %0d token items over three stall mixes",
                 beats_sent, dir_beats, items_checked);
        $display("File ended %s, followed by %0d trailing beats", end_case, n);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/sht_pkg.sv
sv/sccs_history_tokenizer.sv
tb/sccs_history_tokenizer_tb.sv
